// ===== design/posix_cksum_crc32_top_defines.svh =====
// ----------------------------------------------------------------------------
// posix_cksum_crc32 assertion macros
// Concurrent check wrappers used by the checksum datapath.
// ----------------------------------------------------------------------------
`ifndef POSIX_CKSUM_CRC32_TOP_DEFINES_SVH
`define POSIX_CKSUM_CRC32_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define CKCRC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("ckcrc assertion failed");
`define CKCRC_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("ckcrc forbidden condition");
`else
`define CKCRC_ASSERT(label, clk, rst, prop)
`define CKCRC_ASSERT_NEVER(label, clk, rst, cond)
`endif

`endif

// ===== design/ckcrc_pkg.sv =====
// ----------------------------------------------------------------------------
// ckcrc_pkg
// Shared constants, types and the byte-wide CRC-32 update function.
// ----------------------------------------------------------------------------
package ckcrc_pkg;

   localparam int LENGTH_WIDTH = 32;

   localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;

   typedef logic [LENGTH_WIDTH-1:0] len_type;

   localparam len_type LEN_MAX = {LENGTH_WIDTH{1'b1}};

   typedef struct packed {
      logic accept;
      logic trail_step;
      logic finish;
   } ckcrc_cmd_type;

   typedef struct packed {
      logic rem_zero;
      logic out_free;
   } ckcrc_status_type;

   // MSB-first, one byte
   function automatic logic [31:0] crc_feed(input logic [31:0] crc, input logic [7:0] data);
      logic [31:0] c;
      c = crc ^ {data, 24'h0};
      for (int k = 0; k < 8; k++) begin
         c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

endpackage

// ===== design/ckcrc_channels.sv =====
// ----------------------------------------------------------------------------
// ckcrc channels
// Valid/ready interfaces for the byte input and the checksum result.
// ----------------------------------------------------------------------------
interface ckcrc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_valid;
   logic       last;

   modport source (output valid, data_byte, byte_valid, last, input ready);
   modport sink   (input valid, data_byte, byte_valid, last, output ready);
endinterface

interface ckcrc_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] crc_value;
   logic [31:0] byte_count;
   logic        length_overflow;

   modport source (output valid, crc_value, byte_count, length_overflow, input ready);
   modport sink   (input valid, crc_value, byte_count, length_overflow, output ready);
endinterface

// ===== design/posix_cksum_crc32_top.sv =====
// ----------------------------------------------------------------------------
// posix_cksum_crc32_top
// POSIX cksum CRC-32 with appended byte count over a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one byte per transfer (data_byte qualified by byte_valid)
//   and last to close a message; a transfer with byte_valid low and last high
//   ends a message without a byte. rsp_chan carries one result per message:
//   the inverted CRC, the saturated byte count and the overflow flag.
//   Message bytes are taken at one per cycle. After the transfer with last,
//   the length trailer feeds each significant count byte (0 to 4 for a
//   32-bit counter) through the CRC, low byte first, then the result
//   register is loaded when it is free; req ready is low after the
//   transfer with last until that load. The result register parts the two
//   sides: bytes of the next message are taken while a result waits. If rsp
//   ready stays low, the next message's result waits in the trailer state
//   and req ready stays low until taken. Synchronous reset clears the CRC,
//   counter, saturation flag and result valid; req ready rises in the cycle
//   after reset is released.
// ----------------------------------------------------------------------------
module posix_cksum_crc32_top (
   input logic         clock,
   input logic         reset,
   ckcrc_req_if.sink   req_chan,
   ckcrc_rsp_if.source rsp_chan
);
   import ckcrc_pkg::*;

   ckcrc_cmd_type    cmd;
   ckcrc_status_type status;

   ckcrc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_last  (req_chan.last),
      .req_ready (req_chan.ready),
      .cmd       (cmd),
      .status    (status)
   );

   ckcrc_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .data_byte       (req_chan.data_byte),
      .byte_valid      (req_chan.byte_valid),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .crc_value       (rsp_chan.crc_value),
      .byte_count      (rsp_chan.byte_count),
      .length_overflow (rsp_chan.length_overflow)
   );

endmodule

// ===== design/ckcrc_datapath.sv =====
// ----------------------------------------------------------------------------
// ckcrc_datapath
// CRC and byte counter registers, length trailer shifter, result register.
// ----------------------------------------------------------------------------
`include "posix_cksum_crc32_top_defines.svh"

module ckcrc_datapath (
   input  logic                      clock,
   input  logic                      reset,
   input  ckcrc_pkg::ckcrc_cmd_type  cmd,
   output ckcrc_pkg::ckcrc_status_type status,
   input  logic [7:0]                data_byte,
   input  logic                      byte_valid,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [31:0]               crc_value,
   output logic [31:0]               byte_count,
   output logic                      length_overflow
);
   import ckcrc_pkg::*;

   logic [31:0] crc_ff, crc_in;
   len_type     len_ff, len_in;
   logic        sat_ff, sat_in;
   len_type     rem_ff, rem_in;
   logic        out_full_ff, out_full_in;
   logic [31:0] out_crc_ff, out_crc_in;
   logic [31:0] out_count_ff, out_count_in;
   logic        out_ovf_ff, out_ovf_in;

   logic [63:0] len_wide;
   logic        len_big;

   assign len_wide = 64'(len_ff);
   assign len_big  = len_wide > 64'h0000_0000_FFFF_FFFF;

   always_comb begin
      crc_in       = crc_ff;
      len_in       = len_ff;
      sat_in       = sat_ff;
      rem_in       = rem_ff;
      out_full_in  = out_full_ff & ~rsp_ready;
      out_crc_in   = out_crc_ff;
      out_count_in = out_count_ff;
      out_ovf_in   = out_ovf_ff;

      if (cmd.accept) begin
         if (byte_valid) begin
            crc_in = crc_feed(crc_ff, data_byte);
            if (len_ff == LEN_MAX) begin
               sat_in = 1'b1;
            end else begin
               len_in = len_ff + len_type'(1);
            end
         end
         rem_in = len_in;
      end

      if (cmd.trail_step) begin
         crc_in = crc_feed(crc_ff, rem_ff[7:0]);
         rem_in = rem_ff >> 8;
      end

      if (cmd.finish) begin
         out_crc_in   = ~crc_ff;
         out_count_in = len_big ? 32'hFFFF_FFFF : len_wide[31:0];
         out_ovf_in   = sat_ff | len_big;
         out_full_in  = 1'b1;
         crc_in       = '0;
         len_in       = '0;
         sat_in       = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff      <= '0;
         len_ff      <= '0;
         sat_ff      <= 1'b0;
         out_full_ff <= 1'b0;
      end else begin
         crc_ff      <= crc_in;
         len_ff      <= len_in;
         sat_ff      <= sat_in;
         out_full_ff <= out_full_in;
      end
      rem_ff       <= rem_in;
      out_crc_ff   <= out_crc_in;
      out_count_ff <= out_count_in;
      out_ovf_ff   <= out_ovf_in;
   end

   assign status.rem_zero = (rem_ff == '0);
   assign status.out_free = ~out_full_ff | rsp_ready;

   assign rsp_valid       = out_full_ff;
   assign crc_value       = out_crc_ff;
   assign byte_count      = out_count_ff;
   assign length_overflow = out_ovf_ff;

   `CKCRC_ASSERT(a_sat_holds_max, clock, reset, sat_ff |-> (len_ff == LEN_MAX))
   `CKCRC_ASSERT(a_finish_after_trailer, clock, reset, cmd.finish |-> (rem_ff == '0))
   `CKCRC_ASSERT(a_finish_clears, clock, reset,
      cmd.finish |=> (out_full_ff && crc_ff == '0 && len_ff == '0 && !sat_ff))
   `CKCRC_ASSERT_NEVER(a_no_overlap, clock, reset, cmd.accept && (cmd.trail_step || cmd.finish))

endmodule

// ===== design/ckcrc_ctrl.sv =====
// ----------------------------------------------------------------------------
// ckcrc_ctrl
// Sequencer: byte intake, length trailer steps, result hand-off.
// ----------------------------------------------------------------------------
module ckcrc_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_last,
   output logic                        req_ready,
   output ckcrc_pkg::ckcrc_cmd_type    cmd,
   input  ckcrc_pkg::ckcrc_status_type status
);
   import ckcrc_pkg::*;

   typedef enum logic {
      S_RUN,
      S_TRAIL
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;

   always_comb begin
      state_in       = state_ff;
      cmd.accept     = req_valid & ready_ff;
      cmd.trail_step = 1'b0;
      cmd.finish     = 1'b0;
      case (state_ff)
         S_RUN: begin
            if (cmd.accept && req_last) begin
               state_in = S_TRAIL;
            end
         end
         S_TRAIL: begin
            if (!status.rem_zero) begin
               cmd.trail_step = 1'b1;
            end else if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_RUN;
            end
         end
         default: begin
            state_in = S_RUN;
         end
      endcase
      ready_in = (state_in == S_RUN);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_RUN;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

   assign req_ready = ready_ff;

endmodule
